### src/ira_pkg.sv
// Shared constants and controller/datapath signal groups for the interval resource allocator.
package ira_pkg;

  localparam int ID_W              = 10;
  localparam int STALL_W           = 11;
  localparam int ID_SPAN           = 1 << ID_W;
  localparam int MAX_INTERVALS_DEF = 1024;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_END   = 1'b1;

  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

### src/ira_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/ira_ctrl.sv
// Controller state machine: clearing pass, item capture and commit sequencing.
module ira_ctrl
  import ira_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state;
  logic   ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ready <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
            ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid && ready) begin
            state <= ST_LOOKUP;
            ready <= 1'b0;
          end
        end
        ST_LOOKUP: begin
          if (status.out_free) begin
            state <= ST_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= ST_CLEAR;
          ready <= 1'b0;
        end
      endcase
    end
  end

  assign s_tready    = ready;
  assign cmd.clear   = (state == ST_CLEAR);
  assign cmd.capture = ready && s_tvalid;
  assign cmd.commit  = (state == ST_LOOKUP) && status.out_free;

endmodule

### src/ira_dpath.sv
// Datapath: id table, free-list FIFO, counters and output register.
module ira_dpath
  import ira_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   in_mode,
  input  logic [ID_W-1:0]        in_id,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [2*STALL_W-1:0]   m_tdata,
  output logic                   m_tuser
);

  localparam int TBL_DEPTH = (MAX_INTERVALS < ID_SPAN) ? MAX_INTERVALS : ID_SPAN;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

  logic                mode_q;
  logic [ID_W-1:0]     id_q;
  logic [TBL_AW-1:0]   clear_ptr;
  logic [TBL_AW-1:0]   head;
  logic [TBL_AW-1:0]   tail;
  logic [CNT_W-1:0]    queue_count;
  logic [CNT_W-1:0]    open_count;
  logic [CNT_W-1:0]    open_count_next;
  logic [STALL_W-1:0]  out_stall;
  logic [STALL_W-1:0]  out_used;
  logic                out_err;
  logic                out_valid;

  logic                id_wr_en;
  logic [TBL_AW-1:0]   id_addr;
  logic [STALL_W:0]    id_wr_data;
  logic [STALL_W:0]    id_rd_data;
  logic                fifo_wr_en;
  logic [STALL_W-1:0]  fifo_rd_data;

  logic                in_range;
  logic                active;
  logic                err;
  logic                is_start;
  logic                pop;
  logic [STALL_W-1:0]  num;

  assign in_range = (32'(id_q) < MAX_INTERVALS);
  assign active   = id_rd_data[STALL_W];
  assign is_start = (mode_q == MODE_START);
  assign err      = !in_range || (is_start ? active : !active);
  assign pop      = is_start && (queue_count != '0);

  assign open_count_next = (open_count < CNT_W'(TBL_DEPTH)) ? open_count + 1'b1 : open_count;

  always_comb begin
    if (is_start) begin
      num = pop ? fifo_rd_data : STALL_W'(open_count_next);
    end else begin
      num = id_rd_data[STALL_W-1:0];
    end
  end

  always_comb begin
    if (cmd.clear) begin
      id_addr = clear_ptr;
    end else if (cmd.capture) begin
      id_addr = in_id[TBL_AW-1:0];
    end else begin
      id_addr = id_q[TBL_AW-1:0];
    end
  end

  assign id_wr_en   = cmd.clear || (cmd.commit && !err);
  assign id_wr_data = cmd.clear ? '0 : {is_start, num};
  assign fifo_wr_en = cmd.commit && !err && !is_start && (queue_count < CNT_W'(TBL_DEPTH));

  ira_ram #(
    .WIDTH (STALL_W + 1),
    .DEPTH (TBL_DEPTH)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (id_wr_en),
    .wr_addr (id_addr),
    .wr_data (id_wr_data),
    .rd_en   (cmd.capture),
    .rd_addr (id_addr),
    .rd_data (id_rd_data)
  );

  ira_ram #(
    .WIDTH (STALL_W),
    .DEPTH (TBL_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_wr_en),
    .wr_addr (tail),
    .wr_data (num),
    .rd_en   (cmd.capture),
    .rd_addr (head),
    .rd_data (fifo_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= in_mode;
      id_q   <= in_id;
    end
    if (cmd.commit) begin
      out_stall <= err ? '0 : num;
      out_err   <= err;
      out_used  <= STALL_W'((!err && is_start && !pop) ? open_count_next : open_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr   <= '0;
      head        <= '0;
      tail        <= '0;
      queue_count <= '0;
      open_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clear_ptr <= clear_ptr + 1'b1;
      end
      if (cmd.commit && !err) begin
        if (pop) begin
          head        <= (head == TBL_AW'(TBL_DEPTH - 1)) ? '0 : head + 1'b1;
          queue_count <= queue_count - 1'b1;
        end else if (is_start) begin
          open_count <= open_count_next;
        end else if (fifo_wr_en) begin
          tail        <= (tail == TBL_AW'(TBL_DEPTH - 1)) ? '0 : tail + 1'b1;
          queue_count <= queue_count + 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.clear_last = (clear_ptr == TBL_AW'(TBL_DEPTH - 1));
  assign status.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_used, out_stall};
  assign m_tuser  = out_err;

endmodule

### src/interval_resource_allocator_top.sv
// Top level of the interval resource allocator.
// An accepted item's inputs and id table read are registered, then its result goes to the output register.
// A new item is accepted only once the current item's result has entered the output register.
// A stalled result holds the block in its lookup state until it is taken.
// Reset: synchronous; a clearing pass then sweeps all min(MAX_INTERVALS, 1024) id table
// entries, one entry a cycle, with s_tready low.
module interval_resource_allocator_top
  import ira_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] interval_id
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [10:0] assigned_stall, [21:11] stalls_used
  output logic        m_tuser    // [0] error
);

  cmd_t                  cmd;
  status_t               status;
  logic [2*STALL_W-1:0]  result;

  ira_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ira_dpath #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_mode  (s_tuser),
    .in_id    (s_tdata[ID_W-1:0]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (result),
    .m_tuser  (m_tuser)
  );

  assign m_tdata = {2'b00, result};

endmodule

### src/ira_checker.sv
// Port-level assertions for the interval resource allocator, bound to the top level.
module ira_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[10:0] == 11'd0)
    else $error("rejected item carries a resource number");

  a_num_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[10:0] != 11'd0 && m_tdata[10:0] <= m_tdata[21:11])
    else $error("resource number outside the opened range");

endmodule

bind interval_resource_allocator_top ira_checker u_ira_checker (.*);
